[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that ante implies cons in the following cycle, outside of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/srr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg
// Constants and types shared by the selective repeat receiver modules.
// ----------------------------------------------------------------------------
package srr_pkg;

   localparam int SEQ_SPACE    = 8;
   localparam int SEQ_W        = $clog2(SEQ_SPACE);
   localparam int MAX_WINDOW   = 4;
   localparam int CNT_W        = $clog2(MAX_WINDOW);
   localparam int PAYLOAD_BITS = 32;
   localparam int WIN_W        = 3;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_WINDOW = 1'b0;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   localparam int TDATA_W     = 40;
   localparam int TDATA_PAD_W = TDATA_W - SEQ_W - PAYLOAD_BITS;

   typedef struct packed {
      logic                    en;
      logic [SEQ_W-1:0]        addr;
      logic [PAYLOAD_BITS-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic                    kind;
      logic [SEQ_W-1:0]        seq;
      logic [PAYLOAD_BITS-1:0] payload;
      logic                    last;
   } rsp_word_type;

endpackage

[rtl/srr_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_csr
// APB register block holding the receive window size.
// ----------------------------------------------------------------------------
module srr_csr import srr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [WIN_W-1:0]      win_eff
);

   logic [WIN_W-1:0] win_size_ff;
   logic [WIN_W-1:0] win_size_in;
   logic             sel_window;

   assign pready     = 1'b1;
   assign sel_window = (paddr[CSR_ADDR_W-1] == CSR_IDX_WINDOW);

   always_comb begin
      win_size_in = win_size_ff;
      if (psel && penable && pwrite && pready && sel_window) begin
         win_size_in = pwdata[WIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= WINDOW_RESET;
      end else begin
         win_size_ff <= win_size_in;
      end
   end

   assign prdata = sel_window ? CSR_DATA_W'(win_size_ff) : '0;

   // A zero window acts as one; anything above the largest window is clamped.
   always_comb begin
      if (win_size_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (win_size_ff > WIN_W'(MAX_WINDOW)) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = win_size_ff;
      end
   end

endmodule

[rtl/srr_slot_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_slot_mem
// Payload slot memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module srr_slot_mem import srr_pkg::*; (
   input  logic                    clock,
   input  mem_wr_type              wr,
   input  logic [SEQ_W-1:0]        rd_addr,
   output logic [PAYLOAD_BITS-1:0] rd_data
);

   logic [PAYLOAD_BITS-1:0] slot_mem_ff [SEQ_SPACE];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_mem_ff[wr.addr] <= wr.data;
      end
   end

   // Write-first: a read of the slot being written returns the new payload.
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/srr_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_seq
// Packet sequencer: window check, slot update, in-order delivery walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module srr_seq import srr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SEQ_W-1:0]        req_seq,
   input  logic                    req_ok,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic [WIN_W-1:0]        win_eff,
   output mem_wr_type              mem_wr,
   output logic [SEQ_W-1:0]        mem_rd_addr,
   input  logic [PAYLOAD_BITS-1:0] mem_rd_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_word_type            rsp_word
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EVAL = 3'b010,
      S_DLV  = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic                    ok_ff, ok_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [SEQ_W-1:0]        base_ff, base_in;
   logic [SEQ_SPACE-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_word_type            out_word_ff, out_word_in;

   logic [SEQ_W-1:0] ahead;
   logic [SEQ_W-1:0] behind;
   logic [SEQ_W-1:0] base_nxt;
   logic             in_win;
   logic             prev_win;
   logic             head_valid;
   logic             dlv_last;
   logic             out_free;
   logic             out_load;

   assign ahead      = seq_ff - base_ff;
   assign behind     = base_ff - seq_ff;
   assign base_nxt   = base_ff + SEQ_W'(1);
   assign in_win     = (ahead < win_eff);
   assign prev_win   = (behind != '0) && (behind <= win_eff);
   assign head_valid = valid_ff[base_ff] || (seq_ff == base_ff);
   assign dlv_last   = (cnt_ff == CNT_W'(MAX_WINDOW - 1)) || !valid_ff[base_nxt];
   assign out_free   = !out_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      seq_in      = seq_ff;
      ok_in       = ok_ff;
      pay_in      = pay_ff;
      base_in     = base_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      out_load    = 1'b0;
      out_word_in = out_word_ff;
      mem_wr.en   = 1'b0;
      mem_wr.addr = seq_ff;
      mem_wr.data = pay_ff;
      mem_rd_addr = base_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               seq_in   = req_seq;
               ok_in    = req_ok;
               pay_in   = req_payload;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!ok_ff) begin
               state_in = S_IDLE;
            end else if (in_win) begin
               if (out_free) begin
                  out_load            = 1'b1;
                  out_word_in.kind    = KIND_ACK;
                  out_word_in.seq     = seq_ff;
                  out_word_in.payload = '0;
                  out_word_in.last    = !head_valid;
                  // A duplicate keeps the payload already stored.
                  if (!valid_ff[seq_ff]) begin
                     mem_wr.en        = 1'b1;
                     valid_in[seq_ff] = 1'b1;
                  end
                  cnt_in   = '0;
                  state_in = head_valid ? S_DLV : S_IDLE;
               end
            end else if (prev_win) begin
               if (out_free) begin
                  out_load            = 1'b1;
                  out_word_in.kind    = KIND_ACK;
                  out_word_in.seq     = seq_ff;
                  out_word_in.payload = '0;
                  out_word_in.last    = 1'b1;
                  state_in            = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DLV: begin
            if (out_free) begin
               out_load            = 1'b1;
               out_word_in.kind    = KIND_DELIVER;
               out_word_in.seq     = base_ff;
               out_word_in.payload = mem_rd_data;
               out_word_in.last    = dlv_last;
               valid_in[base_ff]   = 1'b0;
               base_in             = base_nxt;
               cnt_in              = cnt_ff + CNT_W'(1);
               // Fetch the next slot now so it is ready in the next cycle.
               mem_rd_addr         = base_nxt;
               if (dlv_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      ok_ff       <= ok_in;
      pay_ff      <= pay_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   `ASSERT_CLK(a_dlv_head_valid, clock, reset, (state_ff == S_DLV) |-> valid_ff[base_ff], "delivery from an empty slot")
   `ASSERT_CLK(a_wr_empty_slot, clock, reset, mem_wr.en |-> !valid_ff[mem_wr.addr], "overwrite of a stored slot")
   `ASSERT_NEXT(a_base_step, clock, reset, out_load && (out_word_in.kind == KIND_DELIVER), base_ff == $past(base_ff) + SEQ_W'(1), "window base did not advance")
   `ASSERT_NEXT(a_last_idle, clock, reset, out_load && out_word_in.last, state_ff == S_IDLE, "sequencer busy after final word")

endmodule

[rtl/selective_repeat_receiver_top.sv]
`timescale 1ns / 1ps
// An accepted packet word is registered and classified in S_EVAL; its acknowledgement is then
// presented from the output register. The input is not ready again until the packet's in-order
// deliveries (0 to 4) are done, the sequencer walking the slot memory one slot per cycle while
// the output is not stalled. A corrupt packet, or one outside this and the last window, frees
// the input with no result. Reset (synchronous, active high) clears the window base, the slot
// flags and the output register and sets the window size to 4; the payload memory is not cleared.
// ----------------------------------------------------------------------------
// selective_repeat_receiver_top
// Receive side of selective-repeat ARQ with a 3-bit sequence space.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_top import srr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Packet input.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,   // seq_num [2:0], payload_word [34:3], zero pad
   input  logic                  req_tuser,   // checksum_ok
   // Result output: acknowledgements and in-order deliveries.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_W-1:0]    rsp_tdata,   // result_seq [2:0], result_payload [34:3], zero pad
   output logic                  rsp_tuser,   // result_kind
   output logic                  rsp_tlast,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Window size after clamping into the legal range.
   logic [WIN_W-1:0]        win_eff;

   // Slot memory access from the sequencer.
   mem_wr_type              mem_wr;
   logic [SEQ_W-1:0]        mem_rd_addr;
   logic [PAYLOAD_BITS-1:0] mem_rd_data;

   // Registered result word from the sequencer.
   rsp_word_type            rsp_word;

   // The register block holds the window size and answers reads combinationally.
   srr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .win_eff (win_eff)
   );

   // Payloads live in the slot memory; the flags that say which slots are
   // occupied are flip-flops in the sequencer, so a never-written slot is
   // never read as a delivery.
   srr_slot_mem u_slot_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The sequencer takes one packet, classifies it against the window, stores
   // it and then walks forward from the window base delivering each stored
   // packet in order. Its output register lets the consumer stall freely.
   srr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_seq     (req_tdata[SEQ_W-1:0]),
      .req_ok      (req_tuser),
      .req_payload (req_tdata[SEQ_W+PAYLOAD_BITS-1:SEQ_W]),
      .win_eff     (win_eff),
      .mem_wr      (mem_wr),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_word    (rsp_word)
   );

   // Pack the result word onto the stream bus.
   assign rsp_tdata = {{TDATA_PAD_W{1'b0}}, rsp_word.payload, rsp_word.seq};
   assign rsp_tuser = rsp_word.kind;
   assign rsp_tlast = rsp_word.last;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective repeat receiver testbench
// Drives packets into the receiver over its stream input and changes the
// window size over the register port between phases. It checks every
// acknowledgement and in-order delivery against a predictor of the receive
// window that runs inside the bench. Directed tests cover the window edges,
// duplicates, corrupt packets, window clamping and a window that shrinks
// while packets are held. A random part then runs mostly well-formed
// traffic around the current window, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench import srr_pkg::*;;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;
   // Byte address of the window size register.
   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW = CSR_ADDR_W'(4 * CSR_IDX_WINDOW);

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Bench copy of the receiver state: the window size register, the window
   // base and the slot buffer. Slot data is only read when its flag is set.
   logic [WIN_W-1:0]        window_setting = WINDOW_RESET;
   logic [SEQ_W-1:0]        rx_base        = '0;
   logic                    slot_full [SEQ_SPACE];
   logic [PAYLOAD_BITS-1:0] slot_data [SEQ_SPACE];

   // Acknowledgements and deliveries still owed by the receiver, oldest first.
   rsp_word_type due_words[$];

   int  error_count   = 0;
   bit  steady_phase  = 1'b0;   // when set, neither side idles
   int  quiet_cycles  = 0;

   selective_repeat_receiver_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The result side stalls at random about 17 percent of the time, except during
   // the steady phase where it always takes the word.
   always @(posedge clock) begin
      rsp_tready <= steady_phase || ($urandom_range(99) >= 17);
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // Sizes above the supported maximum clamp down and zero counts as one.
   function automatic logic [WIN_W-1:0] effective_window();
      logic [WIN_W-1:0] w;
      w = window_setting;
      if (w == '0)
         w = WIN_W'(1);
      if (w > WIN_W'(MAX_WINDOW))
         w = WIN_W'(MAX_WINDOW);
      if (w > WIN_W'(SEQ_SPACE / 2))
         w = WIN_W'(SEQ_SPACE / 2);
      return w;
   endfunction

   // Appends one owed word at the tail of the list.
   function automatic void owe_word(input rsp_word_type word);
      due_words.insert(due_words.size(), word);
   endfunction

   // Works out what one accepted packet makes the receiver send, and updates
   // the window. The sequence arithmetic wraps at the 3-bit width.
   function automatic void arq_accept(input logic [SEQ_W-1:0] seq, input logic ok,
                                      input logic [PAYLOAD_BITS-1:0] payload);
      logic [WIN_W-1:0] w;
      logic [SEQ_W-1:0] ahead;
      logic [SEQ_W-1:0] behind;
      rsp_word_type     word;
      int               n;
      n = 0;
      if (!ok)
         return;
      w      = effective_window();
      ahead  = seq - rx_base;
      behind = rx_base - seq;
      if (ahead < w) begin
         word.kind = KIND_ACK;
         word.seq = seq;
         word.payload = '0;
         word.last = 1'b0;
         owe_word(word);
         n++;
         // A duplicate keeps the payload that arrived first.
         if (!slot_full[seq]) begin
            slot_full[seq] = 1'b1;
            slot_data[seq] = payload;
         end
         for (int i = 0; i < MAX_WINDOW; i++) begin
            if (!slot_full[rx_base])
               break;
            word.kind = KIND_DELIVER;
            word.seq = rx_base;
            word.payload = slot_data[rx_base];
            word.last = 1'b0;
            owe_word(word);
            n++;
            slot_full[rx_base] = 1'b0;
            rx_base = rx_base + SEQ_W'(1);
         end
      end else if (behind >= 1 && behind <= w) begin
         // The sender missed our acknowledgement, so send it again.
         word.kind = KIND_ACK;
         word.seq = seq;
         word.payload = '0;
         word.last = 1'b0;
         owe_word(word);
         n++;
      end
      if (n > 0)
         due_words[due_words.size() - 1].last = 1'b1;
   endfunction

   // Presents one packet and waits for the receiver to take it. Must be
   // entered right after a rising edge. The valid stays high after the
   // handshake so that back-to-back packets need no drop; any caller that
   // does something else next goes through wait_idle, which lowers it.
   task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic ok,
                              input logic [PAYLOAD_BITS-1:0] payload);
      int gap;
      if (!steady_phase && $urandom_range(99) < 17) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {TDATA_PAD_W'(0), payload, seq};
      req_tuser  <= ok;
      do @(posedge clock); while (!req_tready);
      arq_accept(seq, ok, payload);
   endtask

   // Stops sending and waits until every owed word has come back. A packet
   // that makes no result may still be in flight, so the bench lets it settle too.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (due_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the window size and reads it back. Only called while idle.
   task automatic set_window(input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_WINDOW;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // The write lands at this edge; the read setup follows straight on.
      window_setting = value[WIN_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(window_setting))
         report_mismatch("window size read back", 64'(csr_prdata), 64'(window_setting));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Every result word is compared with the oldest owed word, field by field.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_words.size() == 0) begin
            report_mismatch("unexpected word, sequence number", 64'(rsp_tdata[SEQ_W-1:0]), 64'(0));
         end else begin
            want = due_words[0];
            due_words.delete(0);
            if (rsp_tuser !== want.kind)
               report_mismatch("result kind", 64'(rsp_tuser), 64'(want.kind));
            if (rsp_tdata[SEQ_W-1:0] !== want.seq)
               report_mismatch("result sequence number", 64'(rsp_tdata[SEQ_W-1:0]),
                               64'(want.seq));
            if (rsp_tdata[SEQ_W +: PAYLOAD_BITS] !== want.payload)
               report_mismatch("result payload", 64'(rsp_tdata[SEQ_W +: PAYLOAD_BITS]),
                               64'(want.payload));
            if (rsp_tdata[TDATA_W-1 -: TDATA_PAD_W] !== '0)
               report_mismatch("result pad bits", 64'(rsp_tdata[TDATA_W-1 -: TDATA_PAD_W]),
                               64'(0));
            if (rsp_tlast !== want.last)
               report_mismatch("result last flag", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   // Ends a hung run: any handshake or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("selective_repeat_receiver_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Reset window of 4: in-order and out-of-order arrival, the largest
   // in-order run, duplicates, corrupt packets and both window borders.
   task automatic test_default_window();
      send_packet(3'd0, 1'b1, 32'h0000_0000);
      send_packet(3'd3, 1'b1, 32'hFFFF_FFFF);   // two ahead of the window base, held
      send_packet(3'd2, 1'b1, 32'h1234_5678);
      send_packet(3'd1, 1'b1, 32'h8000_0001);   // releases 1, 2 and 3
      send_packet(3'd5, 1'b1, 32'hA5A5_A5A5);
      send_packet(3'd5, 1'b1, 32'h5A5A_5A5A);   // duplicate, first payload stays
      send_packet(3'd4, 1'b0, 32'hFFFF_FFFF);   // corrupt, dropped
      send_packet(3'd4, 1'b1, 32'h0F0F_0F0F);
      // The base is now 6: 3 and 2 lie in the previous window, 1 does not.
      send_packet(3'd3, 1'b1, 32'h1111_1111);
      send_packet(3'd2, 1'b1, 32'h2222_2222);
      send_packet(3'd1, 1'b1, 32'h3333_3333);
      // Fill the window backwards so the last packet releases four words,
      // wrapping the sequence space on the way.
      send_packet(3'd1, 1'b1, 32'hDEAD_BEEF);
      send_packet(3'd0, 1'b1, 32'hCAFE_F00D);
      send_packet(3'd7, 1'b1, 32'h7FFF_FFFE);
      send_packet(3'd6, 1'b1, 32'h0000_0001);
      wait_idle();
   endtask

   // Window sizes of zero and above the maximum, and a window that shrinks
   // while a packet is held beyond its new edge.
   task automatic test_window_sizes();
      set_window(32'd0);                        // taken as one
      send_packet(3'd3, 1'b1, 32'h4444_4444);   // just outside, ignored
      send_packet(3'd1, 1'b1, 32'h5555_5555);   // previous window, acked again
      send_packet(3'd2, 1'b1, 32'h6666_6666);
      wait_idle();
      set_window(32'hFFFF_FFFF);                // low bits 7, clamped to four
      send_packet(3'd6, 1'b1, 32'h7777_7777);   // held
      send_packet(3'd7, 1'b1, 32'h8888_8888);   // one past the window
      send_packet(3'd3, 1'b0, 32'h9999_9999);   // corrupt
      wait_idle();
      set_window(32'd1);                        // slot 6 stays held
      send_packet(3'd3, 1'b1, 32'hAAAA_AAAA);
      send_packet(3'd4, 1'b1, 32'hBBBB_BBBB);
      send_packet(3'd5, 1'b1, 32'hCCCC_CCCC);   // also releases slot 6
      wait_idle();
      set_window(32'd5);
      send_packet(3'd2, 1'b1, 32'hEEEE_EEEE);   // held across later phases
      send_packet(3'd6, 1'b1, 32'h1357_9BDF);
      wait_idle();
      set_window(32'd6);
   endtask

   // Mostly packets inside or just behind the current window with random
   // payloads, plus stray sequence numbers and corrupt packets. With pause
   // set, the sender stops halfway until everything owed has come back.
   task automatic run_traffic(input int count, input bit pause);
      int                      roll;
      logic [WIN_W-1:0]        w;
      logic [SEQ_W-1:0]        seq;
      logic                    ok;
      logic [PAYLOAD_BITS-1:0] payload;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         w    = effective_window();
         ok   = 1'b1;
         if (roll < 65) begin
            seq = rx_base + SEQ_W'($urandom_range(w - 1));
         end else if (roll < 77) begin
            seq = rx_base - SEQ_W'($urandom_range(1, w));
         end else begin
            seq = SEQ_W'($urandom_range(SEQ_SPACE - 1));
            ok  = (roll < 88);
         end
         case ($urandom_range(24))
            0: payload = '0;
            1: payload = '1;
            default: payload = $urandom;
         endcase
         send_packet(seq, ok, payload);
         if (pause && k == count / 2)
            wait_idle();
      end
      wait_idle();
   endtask

   task automatic test_random_traffic();
      set_window(32'd4 | ($urandom & 32'hFFFF_FFF8));
      run_traffic(100, 1'b0);
      // A long stretch without idling on either side.
      set_window(32'd2);
      steady_phase = 1'b1;
      run_traffic(100, 1'b0);
      steady_phase = 1'b0;
      set_window(32'd1 | ($urandom & 32'hFFFF_FFF8));
      run_traffic(100, 1'b1);
      set_window(32'd3);
      run_traffic(100, 1'b0);
   endtask

   initial begin
      for (int i = 0; i < SEQ_SPACE; i++)
         slot_full[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_window();
      test_window_sizes();
      test_random_traffic();
      if (error_count == 0)
         $display("selective_repeat_receiver_top test passed");
      else
         $display("selective_repeat_receiver_top test failed");
      $finish;
   end

endmodule
